// ===== hdl/srps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srps_pkg: shared types and codes of the search-and-remove list
// Depth, widths, command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package srps_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW         = $clog2(LIST_DEPTH + 1);

    typedef logic [31:0]   t_word;
    typedef logic [AW-1:0] t_idx;
    typedef logic [CW-1:0] t_cnt;

    // command codes (slave tuser)
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // status codes (master tuser)
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EQUAL    = 3'd2;
    localparam logic [2:0] ST_PAIR     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic  append;   // load wdata into the cell at index count
        logic  rotate;   // circulate the live entries one place towards cell 0
        logic  drop;     // close the gap at pos
        t_cnt  count;
        t_idx  pos;
        t_word wdata;
    } t_cell_ctl;

endpackage

// ===== hdl/srps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srps_cell: one storage cell of the list chain
// Holds one word; loads, rotates or shifts down from its right-hand neighbour.
// ----------------------------------------------------------------------------
module srps_cell (
    input  logic               i_clk,
    input  srps_pkg::t_idx     i_index,
    input  srps_pkg::t_cell_ctl i_ctl,
    input  srps_pkg::t_word    i_right,
    input  srps_pkg::t_word    i_head,
    output srps_pkg::t_word    o_word
);
    import srps_pkg::*;

    t_word r_word;
    t_cnt  idx_c;

    assign idx_c  = CW'(i_index);
    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (idx_c == i_ctl.count)) begin
            r_word <= i_ctl.wdata;
        end else if (i_ctl.rotate && (idx_c < i_ctl.count)) begin
            // the last live cell wraps round to the head word
            if (idx_c == i_ctl.count - CW'(1)) begin
                r_word <= i_head;
            end else begin
                r_word <= i_right;
            end
        end else if (i_ctl.drop && (i_index >= i_ctl.pos)) begin
            r_word <= i_right;
        end
    end

endmodule

// ===== hdl/search_remove_or_pair_sum_remove_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_remove_or_pair_sum_remove_core: packed word list with search-delete
// Chain of storage cells that circulates the list past cell 0 for searching.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser carries the command (append, query, clear), tdata
//   the word to append or the key. Master channel: tuser carries the status,
//   tdata the removed words and the count left. One result word per input.
//   Append, clear and a query on an empty list are answered straight from
//   idle. A query on a non-empty list rotates the chain once through the
//   live entries looking for an equal entry, then once per outer entry
//   looking for a pair, then compacts the list in S_DROP1 and, for a pair,
//   also S_DROP2. The rotation of the cell chain sets the query time.
//   A new word is taken only in idle, while the result register is free or
//   being emptied in that cycle; a stalled master holds the result and
//   blocks the slave side. Reset empties the list and drops any result.
// ----------------------------------------------------------------------------
module search_remove_or_pair_sum_remove_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [31:0] first_value, [63:32] second_value,
                                     // [70:64] remaining_count, [71] zero
    output logic [2:0]  o_m_tuser    // [2:0] status
);
    import srps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EQ    = 3'd1;
    localparam logic [2:0] S_PAIR  = 3'd2;
    localparam logic [2:0] S_DROP1 = 3'd3;
    localparam logic [2:0] S_DROP2 = 3'd4;

    logic [2:0] r_state;
    t_cnt       r_count;
    t_idx       r_i, r_j, r_pa, r_pb;
    t_word      r_key, r_outer, r_next, r_first, r_second;
    logic       r_found, r_is_pair;
    logic       r_ovalid;
    logic [2:0] r_ostatus;
    t_word      r_ofirst, r_osecond;
    logic [6:0] r_ocount;

    t_word      words [LIST_DEPTH];
    t_cell_ctl  ctl;
    t_word      w0;
    logic       accept, last_step, eq_hit, pair_hit;
    logic [32:0] pair_sum;

    assign w0         = words[0];
    assign o_s_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign last_step  = (CW'(r_j) == r_count - CW'(1));
    assign eq_hit     = !r_found && (w0 == r_key);
    assign pair_sum   = {r_outer[31], r_outer} + {w0[31], w0};
    assign pair_hit   = !r_found && (r_j != r_i) && (pair_sum == {r_key[31], r_key});

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tdata  = {1'b0, r_ocount, r_osecond, r_ofirst};

    always_comb begin
        ctl.append = accept && (i_s_tuser == CMD_APPEND) && (r_count < CW'(LIST_DEPTH));
        ctl.rotate = (r_state == S_EQ) || (r_state == S_PAIR);
        ctl.drop   = (r_state == S_DROP1) || (r_state == S_DROP2);
        ctl.count  = r_count;
        ctl.pos    = (r_state == S_DROP1) ? r_pa : r_pb;
        ctl.wdata  = i_s_tdata;
    end

    genvar k;
    generate
        for (k = 0; k < LIST_DEPTH; k++) begin : g_cell
            t_word right;
            if (k == LIST_DEPTH - 1) begin : g_tail
                assign right = words[k];
            end else begin : g_body
                assign right = words[k+1];
            end
            srps_cell u_cell (
                .i_clk   (i_clk),
                .i_index (AW'(k)),
                .i_ctl   (ctl),
                .i_right (right),
                .i_head  (w0),
                .o_word  (words[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready && !accept) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ofirst  <= '0;
                        r_osecond <= '0;
                        case (i_s_tuser)
                            CMD_APPEND: begin
                                r_ovalid <= 1'b1;
                                if (r_count < CW'(LIST_DEPTH)) begin
                                    r_count   <= r_count + CW'(1);
                                    r_ostatus <= ST_DONE;
                                    r_ocount  <= 7'(r_count + CW'(1));
                                end else begin
                                    r_ostatus <= ST_FULL;
                                    r_ocount  <= 7'(r_count);
                                end
                            end
                            CMD_CLEAR: begin
                                r_ovalid  <= 1'b1;
                                r_count   <= '0;
                                r_ostatus <= ST_DONE;
                                r_ocount  <= '0;
                            end
                            CMD_QUERY: begin
                                if (r_count == '0) begin
                                    r_ovalid  <= 1'b1;
                                    r_ostatus <= ST_NOTFOUND;
                                    r_ocount  <= '0;
                                end else begin
                                    r_ovalid <= 1'b0;
                                    r_state  <= S_EQ;
                                    r_key    <= i_s_tdata;
                                    r_j      <= '0;
                                    r_found  <= 1'b0;
                                end
                            end
                            default: begin
                                r_ovalid  <= 1'b1;
                                r_ostatus <= ST_NOTFOUND;
                                r_ocount  <= 7'(r_count);
                            end
                        endcase
                    end
                end
                S_EQ: begin
                    if (eq_hit) begin
                        r_found <= 1'b1;
                        r_pa    <= r_j;
                        r_first <= w0;
                    end
                    if (last_step) begin
                        // chain is back in list order after this step
                        if (r_found || eq_hit) begin
                            r_state   <= S_DROP1;
                            r_is_pair <= 1'b0;
                            r_second  <= '0;
                        end else begin
                            r_state <= S_PAIR;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_found <= 1'b0;
                        end
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_PAIR: begin
                    // outer word for the first pass, and pick up the next one
                    if ((r_i == '0) && (r_j == '0)) begin
                        r_outer <= w0;
                    end
                    if (CW'(r_j) == CW'(r_i) + CW'(1)) begin
                        r_next <= w0;
                    end
                    if (pair_hit) begin
                        r_found  <= 1'b1;
                        r_first  <= r_outer;
                        r_second <= w0;
                        r_pa     <= (r_i > r_j) ? r_i : r_j;
                        r_pb     <= (r_i > r_j) ? r_j : r_i;
                    end
                    if (last_step) begin
                        r_j <= '0;
                        if (r_found || pair_hit) begin
                            r_state   <= S_DROP1;
                            r_is_pair <= 1'b1;
                        end else if (CW'(r_i) == r_count - CW'(1)) begin
                            r_state   <= S_IDLE;
                            r_ovalid  <= 1'b1;
                            r_ostatus <= ST_NOTFOUND;
                            r_ofirst  <= '0;
                            r_osecond <= '0;
                            r_ocount  <= 7'(r_count);
                        end else begin
                            r_i <= r_i + AW'(1);
                            // next outer word may sit at cell 0 in this very step
                            r_outer <= (CW'(r_j) == CW'(r_i) + CW'(1)) ? w0 : r_next;
                        end
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_DROP1: begin
                    r_count <= r_count - CW'(1);
                    if (r_is_pair) begin
                        r_state <= S_DROP2;
                    end else begin
                        r_state   <= S_IDLE;
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_EQUAL;
                        r_ofirst  <= r_first;
                        r_osecond <= '0;
                        r_ocount  <= 7'(r_count - CW'(1));
                    end
                end
                S_DROP2: begin
                    r_count   <= r_count - CW'(1);
                    r_state   <= S_IDLE;
                    r_ovalid  <= 1'b1;
                    r_ostatus <= ST_PAIR;
                    r_ofirst  <= r_first;
                    r_osecond <= r_second;
                    r_ocount  <= 7'(r_count - CW'(1));
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
